[rtl/bcc_pkg.sv]
// Shared constants for the button click classifier: window length,
// timer width, phase and event codes, configuration register indexes.
// No dependencies.
package bcc_pkg;

    // Debounce window length in samples (1..16) and tick timer width (8..32)
    localparam int DEBOUNCE_SAMPLES = 10;
    localparam int TIMER_BITS       = 16;

    // Threshold registers are 16 bits; compares run at the wider of the two
    localparam int THRESH_BITS = 16;
    localparam int CMP_BITS    = (TIMER_BITS > THRESH_BITS) ? TIMER_BITS : THRESH_BITS;

    // Configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_LEVEL = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DOUBLE_TICKS = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_LONG_TICKS   = 2'd2;

    localparam logic [THRESH_BITS-1:0] DOUBLE_TICKS_RESET = 16'd60;
    localparam logic [THRESH_BITS-1:0] LONG_TICKS_RESET   = 16'd200;

    // Phase codes
    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_PRESS1   = 2'd1;
    localparam logic [1:0] PH_RELEASE1 = 2'd2;
    localparam logic [1:0] PH_COOLDOWN = 2'd3;

    // Event codes
    typedef logic [1:0] event_t;
    localparam event_t EV_NONE   = 2'd0;
    localparam event_t EV_CLICK  = 2'd1;
    localparam event_t EV_DOUBLE = 2'd2;
    localparam event_t EV_LONG   = 2'd3;

    // One result as it sits in the output buffer
    typedef struct packed {
        event_t event_code;
        logic   debounced_down;
    } result_t;

endpackage

[rtl/button_click_classifier_top.sv]
// Button click classifier: debounce window, four-phase click machine,
// two-entry output buffer. Depends on bcc_pkg.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    s_raw_level
//   m_        out        m_valid/m_ready    m_event_code, m_debounced_down
//   cfg_      in         cfg_we             cfg_index, cfg_data
//
// One sample per cycle while s_ready is high: the history, phase and timer update
// in the cycle the request is taken, and its result is registered into the output buffer.
// A result waiting at m_ leaves room for one more request in the skid entry;
// s_ready drops only while both output entries are full.
// Reset (aresetn low at a clock edge) sets history to released, phase idle,
// timer zero, registers to their defaults, and empties the output buffer.
module button_click_classifier_top
    import bcc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_raw_level,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_event_code,
    output logic                     m_debounced_down,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    // Configuration registers
    logic                   active_level_reg;
    logic [THRESH_BITS-1:0] double_ticks_reg;
    logic [THRESH_BITS-1:0] long_ticks_reg;

    // Classifier state
    logic [DEBOUNCE_SAMPLES-1:0] hist_reg, hist_next;
    logic [1:0]                  phase_reg, phase_next;
    logic [TIMER_BITS-1:0]       elapsed_reg, elapsed_next;

    // Output buffer
    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;
    result_t result_next;

    logic                        s_fire, m_fire;
    logic [DEBOUNCE_SAMPLES:0]   hist_ext;
    logic                        down;
    logic [TIMER_BITS-1:0]       elapsed_inc;
    logic                        long_hit, double_timeout;
    event_t                      ev;

    assign s_ready = !skid_valid_reg;
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = out_valid_reg && m_ready;

    assign m_valid          = out_valid_reg;
    assign m_event_code     = out_reg.event_code;
    assign m_debounced_down = out_reg.debounced_down;

    // Configuration writes; unknown index is ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_level_reg <= 1'b0;
            double_ticks_reg <= DOUBLE_TICKS_RESET;
            long_ticks_reg   <= LONG_TICKS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ACTIVE_LEVEL: active_level_reg <= cfg_data[0];
                REG_DOUBLE_TICKS: double_ticks_reg <= cfg_data[THRESH_BITS-1:0];
                REG_LONG_TICKS:   long_ticks_reg   <= cfg_data[THRESH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Shift in the new sample (1 = released) and check the window
    assign hist_ext  = {hist_reg, (s_raw_level != active_level_reg)};
    assign hist_next = hist_ext[DEBOUNCE_SAMPLES-1:0];
    assign down      = (hist_next == '0);

    // Saturating timer step and threshold compares on the stepped value
    assign elapsed_inc    = (elapsed_reg == TIMER_MAX) ? elapsed_reg
                                                       : elapsed_reg + TIMER_BITS'(1);
    assign long_hit       = CMP_BITS'(elapsed_inc) > CMP_BITS'(long_ticks_reg);
    assign double_timeout = CMP_BITS'(elapsed_inc) > CMP_BITS'(double_ticks_reg);

    // Phase machine
    always_comb begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        ev           = EV_NONE;
        unique case (phase_reg)
            PH_IDLE: begin
                if (down) begin
                    elapsed_next = '0;
                    phase_next   = PH_PRESS1;
                end
            end
            PH_PRESS1: begin
                elapsed_next = elapsed_inc;
                if (down) begin
                    if (long_hit) begin
                        ev         = EV_LONG;
                        phase_next = PH_COOLDOWN;
                    end
                end else begin
                    phase_next = PH_RELEASE1;
                end
            end
            PH_RELEASE1: begin
                elapsed_next = elapsed_inc;
                // timeout takes priority over a second press
                if (double_timeout) begin
                    ev         = EV_CLICK;
                    phase_next = PH_IDLE;
                end else if (down) begin
                    ev         = EV_DOUBLE;
                    phase_next = PH_COOLDOWN;
                end
            end
            PH_COOLDOWN: begin
                if (!down) begin
                    phase_next = PH_IDLE;
                end
            end
            default: ;
        endcase
    end

    assign result_next.event_code     = ev;
    assign result_next.debounced_down = down;

    // State update on each accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg    <= '1;
            phase_reg   <= PH_IDLE;
            elapsed_reg <= '0;
        end else if (s_fire) begin
            hist_reg    <= hist_next;
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // Output buffer control: main entry plus one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_fire) begin
            // skid is empty whenever a request is taken
            out_valid_reg  <= skid_valid_reg || s_fire;
            skid_valid_reg <= 1'b0;
        end else if (s_fire) begin
            if (!out_valid_reg) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Output buffer data
    always_ff @(posedge aclk) begin
        if (m_fire && skid_valid_reg) begin
            out_reg <= skid_reg;
        end else if (s_fire && (!out_valid_reg || m_fire)) begin
            out_reg <= result_next;
        end
        if (s_fire && out_valid_reg && !m_fire) begin
            skid_reg <= result_next;
        end
    end

    // Skid entry is only used behind a full main entry
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while main entry empty");

    // Long press and double click are only reported while held down
    a_event_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_event_code == EV_LONG || m_event_code == EV_DOUBLE))
            |-> m_debounced_down)
        else $error("press event reported while released");

    // Classifier state changes only on an accepted request
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_fire |=> ($stable(phase_reg) && $stable(hist_reg) && $stable(elapsed_reg)))
        else $error("classifier state moved without a request");

    // A reported event always leaves the first-press or first-release phase
    a_event_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && ev != EV_NONE) |=> (phase_reg == PH_IDLE || phase_reg == PH_COOLDOWN))
        else $error("event reported but phase did not leave the click window");

endmodule
